// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Assertion helpers used by the parse engine RTL (lrpe_engine.sv).
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

// ----- hdl/lrpe_pkg.sv -----
// ----------------------------------------------------------------------------
// LR parse engine package
// Shared types and field widths for the LR table parse engine.
// ----------------------------------------------------------------------------
package lrpe_pkg;

  localparam int ROW_W       = 8;
  localparam int COL_W       = 6;
  localparam int VAL_W       = 9;
  localparam int TOK_W       = 6;
  localparam int LEN_W       = 7;
  localparam int STATE_W     = 8;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic [1:0] {
    FUNC_WR_ACTION = 2'd0,
    FUNC_WR_GOTO   = 2'd1,
    FUNC_WR_RULE   = 2'd2,
    FUNC_TOKEN     = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    EV_SHIFT  = 2'd0,
    EV_REDUCE = 2'd1,
    EV_ACCEPT = 2'd2,
    EV_ERROR  = 2'd3
  } event_e;

  typedef struct packed {
    func_e                    func;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic signed [VAL_W-1:0]  val;
    logic [LEN_W-1:0]         rule_len;
    logic [COL_W-1:0]         lhs;
    logic [TOK_W-1:0]         token;
  } cmd_t;

endpackage

// ----- hdl/lrpe_queue.sv -----
// ----------------------------------------------------------------------------
// LR parse engine front end
// Accepts input transactions, decodes them into commands and buffers them
// in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module lrpe_queue (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             enable_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [lrpe_pkg::IN_TDATA_W-1:0]  in_tdata_i,
  input  logic [1:0]                       in_func_i,
  output logic                             out_valid_o,
  output lrpe_pkg::cmd_t                   out_cmd_o,
  input  logic                             out_pop_i
);
  import lrpe_pkg::*;

  cmd_t       buf_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  cmd_t       dec;
  logic       push, pop;

  always_comb begin
    dec.func  = func_e'(in_func_i);
    dec.row   = in_tdata_i[7:0];
    dec.col   = in_tdata_i[13:8];
    dec.val   = in_tdata_i[22:14];
    dec.lhs   = in_tdata_i[28:23];
    dec.token = in_tdata_i[34:29];
    // Rule length saturates to 0..127.
    if (dec.val[8]) begin
      dec.rule_len = '0;
    end else if (dec.val[7]) begin
      dec.rule_len = '1;
    end else begin
      dec.rule_len = dec.val[6:0];
    end
  end

  assign in_ready_o  = enable_i && (cnt_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_pop_i && out_valid_o;
  assign out_cmd_o   = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_ptr_q] <= dec;
  end

endmodule

// ----- hdl/lrpe_engine.sv -----
// ----------------------------------------------------------------------------
// LR parse engine back end
// Holds the ACTION, GOTO, rule and state stack memories and steps the
// shift/reduce loop for each token command.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lrpe_engine #(
  parameter int STATES       = 256,
  parameter int TERMINALS    = 64,
  parameter int NONTERMINALS = 64,
  parameter int RULES        = 256,
  parameter int STACK_DEPTH  = 64,
  parameter int REDUCE_LIMIT = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic signed [lrpe_pkg::VAL_W-1:0]  accept_code_i,
  input  logic                               cmd_valid_i,
  input  lrpe_pkg::cmd_t                     cmd_i,
  output logic                               cmd_pop_o,
  output logic                               clearing_o,
  output logic                               m_valid_o,
  input  logic                               m_ready_i,
  output lrpe_pkg::event_e                   m_kind_o,
  output logic [lrpe_pkg::STATE_W-1:0]       m_value_o,
  output logic                               m_last_o
);
  import lrpe_pkg::*;

  localparam int SW  = (STATES > 1) ? $clog2(STATES) : 1;
  localparam int TW  = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;
  localparam int NW  = (NONTERMINALS > 1) ? $clog2(NONTERMINALS) : 1;
  localparam int RW  = (RULES > 1) ? $clog2(RULES) : 1;
  localparam int DW  = $clog2(STACK_DEPTH);
  localparam int CW  = DW + 1;
  localparam int RCW = $clog2(REDUCE_LIMIT + 1);
  localparam int AW  = SW + TW;
  localparam int GW  = SW + NW;
  localparam int CLW = (AW > GW) ? ((AW > RW) ? AW : RW) : ((GW > RW) ? GW : RW);

  typedef enum logic [2:0] {
    ST_CLR, ST_IDLE, ST_DEC, ST_RULE, ST_GOTO, ST_PUSH
  } state_e;

  // Memories.
  logic signed [VAL_W-1:0] act_mem  [2**AW];
  logic [STATE_W-1:0]      goto_mem [2**GW];
  logic [LEN_W-1:0]        len_mem  [2**RW];
  logic [COL_W-1:0]        lhs_mem  [2**RW];
  logic [STATE_W-1:0]      stk_mem  [2**DW];

  logic                    act_we, act_re;
  logic [AW-1:0]           act_waddr, act_raddr;
  logic signed [VAL_W-1:0] act_wdata, act_rd_q;
  logic                    goto_we, goto_re;
  logic [GW-1:0]           goto_waddr, goto_raddr;
  logic [STATE_W-1:0]      goto_wdata, goto_rd_q;
  logic                    rule_we, rule_re;
  logic [RW-1:0]           rule_waddr, rule_raddr;
  logic [LEN_W-1:0]        len_wdata, len_rd_q;
  logic [COL_W-1:0]        lhs_wdata, lhs_rd_q;
  logic                    stk_we, stk_re;
  logic [DW-1:0]           stk_waddr, stk_raddr;
  logic [STATE_W-1:0]      stk_wdata, stk_rd_q;

  state_e             state_q, state_d;
  logic [CLW-1:0]     clr_cnt_q, clr_cnt_d;
  logic [STATE_W-1:0] top_q, top_d;
  logic [CW-1:0]      sc_q, sc_d, newsc_q, newsc_d;
  logic [RCW-1:0]     red_q, red_d;
  logic [TOK_W-1:0]   tok_q, tok_d;
  logic [STATE_W-1:0] rule_q, rule_d;
  logic [COL_W-1:0]   lhs_q, lhs_d;
  logic               act_ok_q, act_ok_d, goto_ok_q, goto_ok_d, base_q, base_d;
  logic               ov_q, ov_d, olast_q, olast_d;
  event_e             okind_q, okind_d;
  logic [STATE_W-1:0] oval_q, oval_d;

  always_comb begin
    logic signed [VAL_W-1:0] ac;
    logic [VAL_W-1:0]        rule9;
    logic                    err;
    logic                    out_free;
    logic [STATE_W-1:0]      g, s;
    logic [CW-1:0]           newsc;

    state_d = state_q;  clr_cnt_d = clr_cnt_q;  top_d = top_q;  sc_d = sc_q;
    newsc_d = newsc_q;  red_d = red_q;  tok_d = tok_q;  rule_d = rule_q;
    lhs_d = lhs_q;  act_ok_d = act_ok_q;  goto_ok_d = goto_ok_q;  base_d = base_q;
    ov_d = ov_q;  olast_d = olast_q;  okind_d = okind_q;  oval_d = oval_q;
    act_we = 1'b0;  act_re = 1'b0;  act_waddr = '0;  act_raddr = '0;  act_wdata = '0;
    goto_we = 1'b0; goto_re = 1'b0; goto_waddr = '0; goto_raddr = '0; goto_wdata = '0;
    rule_we = 1'b0; rule_re = 1'b0; rule_waddr = '0; rule_raddr = '0;
    len_wdata = '0; lhs_wdata = '0;
    stk_we = 1'b0;  stk_re = 1'b0;  stk_waddr = '0;  stk_raddr = '0;  stk_wdata = '0;
    cmd_pop_o = 1'b0;
    err = 1'b0;
    ac = '0;  rule9 = '0;  g = '0;  s = '0;  newsc = '0;

    out_free = !ov_q || m_ready_i;
    if (ov_q && m_ready_i) ov_d = 1'b0;

    case (state_q)
      ST_CLR: begin
        act_we     = 1'b1;
        act_waddr  = clr_cnt_q[AW-1:0];
        goto_we    = 1'b1;
        goto_waddr = clr_cnt_q[GW-1:0];
        rule_we    = 1'b1;
        rule_waddr = clr_cnt_q[RW-1:0];
        clr_cnt_d  = CLW'(clr_cnt_q + 1'b1);
        if (&clr_cnt_q) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.func)
            FUNC_WR_ACTION: begin
              act_we    = ({1'b0, cmd_i.row} < 9'(STATES)) &&
                          ({1'b0, cmd_i.col} < 7'(TERMINALS));
              act_waddr = {cmd_i.row[SW-1:0], cmd_i.col[TW-1:0]};
              act_wdata = cmd_i.val;
            end
            FUNC_WR_GOTO: begin
              goto_we    = ({1'b0, cmd_i.row} < 9'(STATES)) &&
                           ({1'b0, cmd_i.col} < 7'(NONTERMINALS));
              goto_waddr = {cmd_i.row[SW-1:0], cmd_i.col[NW-1:0]};
              goto_wdata = cmd_i.val[STATE_W-1:0];
            end
            FUNC_WR_RULE: begin
              rule_we    = ({1'b0, cmd_i.row} < 9'(RULES));
              rule_waddr = cmd_i.row[RW-1:0];
              len_wdata  = cmd_i.rule_len;
              lhs_wdata  = cmd_i.lhs;
            end
            FUNC_TOKEN: begin
              tok_d     = cmd_i.token;
              red_d     = '0;
              act_re    = 1'b1;
              act_raddr = {top_q[SW-1:0], cmd_i.token[TW-1:0]};
              act_ok_d  = ({1'b0, top_q} < 9'(STATES)) &&
                          ({1'b0, cmd_i.token} < 7'(TERMINALS));
              state_d   = ST_DEC;
            end
            default: ;
          endcase
        end
      end
      ST_DEC: begin
        ac = act_ok_q ? act_rd_q : '0;
        // The accept code is checked before everything else.
        if (ac == accept_code_i) begin
          if (out_free) begin
            ov_d = 1'b1;  okind_d = EV_ACCEPT;  oval_d = STATE_W'(tok_q);  olast_d = 1'b1;
            sc_d = CW'(1);  top_d = '0;  red_d = '0;
            state_d = ST_IDLE;
          end
        end else if (ac == '0) begin
          err = 1'b1;
        end else if (!ac[VAL_W-1]) begin
          if (sc_q >= CW'(STACK_DEPTH)) begin
            err = 1'b1;
          end else if (out_free) begin
            stk_we    = 1'b1;
            stk_waddr = sc_q[DW-1:0];
            stk_wdata = ac[STATE_W-1:0];
            top_d     = ac[STATE_W-1:0];
            sc_d      = CW'(sc_q + 1'b1);
            ov_d = 1'b1;  okind_d = EV_SHIFT;  oval_d = ac[STATE_W-1:0];  olast_d = 1'b1;
            state_d   = ST_IDLE;
          end
        end else begin
          rule9 = VAL_W'(-ac);
          if (({1'b0, rule9} >= 10'(RULES)) || (red_q >= RCW'(REDUCE_LIMIT))) begin
            err = 1'b1;
          end else begin
            rule_re    = 1'b1;
            rule_raddr = rule9[RW-1:0];
            rule_d     = rule9[STATE_W-1:0];
            state_d    = ST_RULE;
          end
        end
      end
      ST_RULE: begin
        if ((8'(len_rd_q) >= 8'(sc_q)) ||
            ((len_rd_q == '0) && (sc_q >= CW'(STACK_DEPTH)))) begin
          err = 1'b1;
        end else begin
          newsc     = CW'(8'(sc_q) - 8'(len_rd_q));
          stk_re    = 1'b1;
          stk_raddr = DW'(newsc - 1'b1);
          // Entry zero is never written; when the count drops to one, start state zero is used instead.
          base_d    = (newsc == CW'(1));
          newsc_d   = newsc;
          lhs_d     = lhs_rd_q;
          state_d   = ST_GOTO;
        end
      end
      ST_GOTO: begin
        s          = base_q ? '0 : stk_rd_q;
        goto_re    = 1'b1;
        goto_raddr = {s[SW-1:0], lhs_q[NW-1:0]};
        goto_ok_d  = ({1'b0, s} < 9'(STATES)) && ({1'b0, lhs_q} < 7'(NONTERMINALS));
        state_d    = ST_PUSH;
      end
      ST_PUSH: begin
        if (out_free) begin
          g         = goto_ok_q ? goto_rd_q : '0;
          stk_we    = 1'b1;
          stk_waddr = newsc_q[DW-1:0];
          stk_wdata = g;
          top_d     = g;
          sc_d      = CW'(newsc_q + 1'b1);
          red_d     = RCW'(red_q + 1'b1);
          ov_d = 1'b1;  okind_d = EV_REDUCE;  oval_d = rule_q;  olast_d = 1'b0;
          act_re    = 1'b1;
          act_raddr = {g[SW-1:0], tok_q[TW-1:0]};
          act_ok_d  = ({1'b0, g} < 9'(STATES)) && ({1'b0, tok_q} < 7'(TERMINALS));
          state_d   = ST_DEC;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (err && out_free) begin
      ov_d = 1'b1;  okind_d = EV_ERROR;  oval_d = STATE_W'(tok_q);  olast_d = 1'b1;
      sc_d = CW'(1);  top_d = '0;  red_d = '0;
      state_d = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLR;
      clr_cnt_q <= '0;
      top_q     <= '0;
      sc_q      <= CW'(1);
      newsc_q   <= CW'(1);
      red_q     <= '0;
      act_ok_q  <= 1'b0;
      goto_ok_q <= 1'b0;
      base_q    <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      top_q     <= top_d;
      sc_q      <= sc_d;
      newsc_q   <= newsc_d;
      red_q     <= red_d;
      act_ok_q  <= act_ok_d;
      goto_ok_q <= goto_ok_d;
      base_q    <= base_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q   <= tok_d;
    rule_q  <= rule_d;
    lhs_q   <= lhs_d;
    olast_q <= olast_d;
    okind_q <= okind_d;
    oval_q  <= oval_d;
  end

  always_ff @(posedge clk_i) begin
    if (act_we) act_mem[act_waddr] <= act_wdata;
    if (act_re) act_rd_q <= act_mem[act_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (goto_we) goto_mem[goto_waddr] <= goto_wdata;
    if (goto_re) goto_rd_q <= goto_mem[goto_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rule_we) begin
      len_mem[rule_waddr] <= len_wdata;
      lhs_mem[rule_waddr] <= lhs_wdata;
    end
    if (rule_re) begin
      len_rd_q <= len_mem[rule_raddr];
      lhs_rd_q <= lhs_mem[rule_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    if (stk_re) stk_rd_q <= stk_mem[stk_raddr];
  end

  assign clearing_o = (state_q == ST_CLR);
  assign m_valid_o  = ov_q;
  assign m_kind_o   = okind_q;
  assign m_value_o  = oval_q;
  assign m_last_o   = olast_q;

  `ASSERT_CLK(a_stack_range, (sc_q != '0) && (sc_q <= CW'(STACK_DEPTH)), "stack count out of range")
  `ASSERT_CLK(a_reduce_limit, red_q <= RCW'(REDUCE_LIMIT), "reduce count beyond limit")
  `ASSERT_NEVER(a_clear_quiet, (state_q == ST_CLR) && (ov_q || cmd_pop_o), "activity during clear")

endmodule

// ----- hdl/lr_table_parse_engine_unit.sv -----
// A load transaction is written to its table as the idle engine takes it; a token reads
// ACTION for the decode state (shift, accept or table error), an error at the rule lookup
// comes from the rule state, and each reduce runs the rule, GOTO and push states on the
// registered ACTION, rule, stack and GOTO reads. Tokens wait until the last is through;
// one load per cycle while idle. Reset: asynchronous, active low; a pass over 2**max(SW+TW,
// SW+NW, RW) addresses (16384 by default) then zeroes the tables, taking no stream input.
// ----------------------------------------------------------------------------
// LR table parse engine
// Table-driven LR parser with loadable ACTION, GOTO and rule tables.
// ----------------------------------------------------------------------------
module lr_table_parse_engine_unit #(
  parameter int STATES       = 256,
  parameter int TERMINALS    = 64,
  parameter int NONTERMINALS = 64,
  parameter int RULES        = 256,
  parameter int STACK_DEPTH  = 64,
  parameter int REDUCE_LIMIT = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [lrpe_pkg::VAL_W-1:0]           cfg_data_i,    // accept_code
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // row_index[7:0], column_index[13:8], entry_value[22:14], rule_lhs[28:23], token[34:29]
  input  logic [lrpe_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  input  logic [1:0]                           s_axis_tuser,  // func
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [lrpe_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // event_value
  output logic [1:0]                           m_axis_tuser,  // event_kind
  output logic                                 m_axis_tlast   // last_of_run
);
  import lrpe_pkg::*;

  logic signed [VAL_W-1:0] accept_q;
  logic                    cmd_valid, cmd_pop, clearing;
  cmd_t                    cmd;
  event_e                  kind;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accept_q <= -9'sd256;
    end else if (cfg_valid_i) begin
      accept_q <= cfg_data_i;
    end
  end

  lrpe_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .enable_i    (!clearing),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_tdata_i  (s_axis_tdata),
    .in_func_i   (s_axis_tuser),
    .out_valid_o (cmd_valid),
    .out_cmd_o   (cmd),
    .out_pop_i   (cmd_pop)
  );

  lrpe_engine #(
    .STATES       (STATES),
    .TERMINALS    (TERMINALS),
    .NONTERMINALS (NONTERMINALS),
    .RULES        (RULES),
    .STACK_DEPTH  (STACK_DEPTH),
    .REDUCE_LIMIT (REDUCE_LIMIT)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_code_i (accept_q),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_pop_o     (cmd_pop),
    .clearing_o    (clearing),
    .m_valid_o     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .m_kind_o      (kind),
    .m_value_o     (m_axis_tdata),
    .m_last_o      (m_axis_tlast)
  );

  assign m_axis_tuser = kind;

endmodule
